/* src/card_number_luhn_classifier_assert.svh */
// Assertion macros for the card number classifier.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define CNL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define CNL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/cnl_pkg.sv */
//------------------------------------------------------------------------------
// cnl_pkg
// Shared widths and constants for the card number classifier.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package cnl_pkg;
    localparam int CARD_W        = 54;
    localparam int DIGITS        = 17;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int DABBLE_STAGES = 9;    // 54 shift steps, 6 per stage
    localparam int COUNT_W       = 5;
    localparam int CLASS_W       = 2;
    localparam int SUM_W         = 8;    // 17 digits * 9 max = 153
    localparam int SUM_MAX       = 153;
    localparam int PART_N        = 5;    // four groups of four digits, plus the top digit
    localparam int PART_W        = 6;    // 4 * 9 = 36

    localparam logic [CLASS_W-1:0] CLS_NONE = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_P4   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_P3X  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_P5X  = 2'd3;

    // BCD digits on top, remaining binary bits below; shifted as one word.
    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [CARD_W-1:0] bin;
    } t_dabble_state;
endpackage

/* src/cnl_digit_stage.sv */
//------------------------------------------------------------------------------
// cnl_digit_stage
// One pipeline stage of the binary to BCD conversion: a few shift-and-add-3
// steps, with a valid/ready register at the output.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module cnl_digit_stage #(
    parameter int STEPS = cnl_pkg::CARD_W / cnl_pkg::DABBLE_STAGES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  cnl_pkg::t_dabble_state i_state,
    output logic                   o_valid,
    input  logic                   i_ready,
    output cnl_pkg::t_dabble_state o_state
);
    import cnl_pkg::*;

    logic          r_valid;
    t_dabble_state r_state;
    t_dabble_state n_state;

    // Each step: bump every digit >= 5 by 3 so it carries on doubling,
    // then shift the next binary bit in from the top of the input word.
    always_comb begin
        n_state = i_state;
        for (int s = 0; s < STEPS; s++) begin
            for (int k = 0; k < DIGITS; k++) begin
                if (n_state.bcd[4*k +: 4] >= 4'd5) begin
                    n_state.bcd[4*k +: 4] = n_state.bcd[4*k +: 4] + 4'd3;
                end
            end
            {n_state.bcd, n_state.bin} = {n_state.bcd, n_state.bin} << 1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule

/* src/card_number_luhn_classifier.sv */
//------------------------------------------------------------------------------
// card_number_luhn_classifier
// Luhn mod-10 check, digit count and prefix classification of a card number.
//------------------------------------------------------------------------------
// Each transaction runs through NSTAGE + 2 register stages (11 by default).
// The first NSTAGE stages convert the 54-bit number to 17 BCD digits by
// shift-and-add-3, 54 / NSTAGE bit steps per stage (NSTAGE must divide 54).
// The next stage weights the digits for Luhn, adds them in groups of four,
// and finds the digit count and the two leading digits; the last stage
// finishes the sum, tests it against the multiples of ten and classifies.
// The result is presented from the final stage register. A new transaction may
// enter every cycle, so throughput is one per cycle while the output is taken.
// Ready backpressure passes stage by stage; no transaction is lost or repeated.
`timescale 1ns / 1ps
module card_number_luhn_classifier #(
    parameter int NSTAGE = cnl_pkg::DABBLE_STAGES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cnl_pkg::CARD_W-1:0]    i_card_number,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cnl_pkg::CLASS_W-1:0]   o_card_class,
    output logic                          o_luhn_ok,
    output logic [cnl_pkg::COUNT_W-1:0]   o_digit_count
);
    import cnl_pkg::*;
    `include "card_number_luhn_classifier_assert.svh"

    localparam int STEPS = CARD_W / NSTAGE;

    logic          w_v [NSTAGE+1];
    logic          w_r [NSTAGE+1];
    t_dabble_state w_s [NSTAGE+1];

    // Digit evaluation stage
    logic [3:0]         w_dig [DIGITS];
    logic [3:0]         w_wt  [DIGITS];
    logic [PART_W-1:0]  n_e_part [PART_N];
    logic [COUNT_W-1:0] n_e_count;
    logic [3:0]         n_e_hi;
    logic [3:0]         n_e_lo;
    logic               w_e_ready;
    logic               r_e_valid;
    logic [PART_W-1:0]  r_e_part [PART_N];
    logic [COUNT_W-1:0] r_e_count;
    logic [3:0]         r_e_hi;
    logic [3:0]         r_e_lo;

    // Final stage
    logic [SUM_W-1:0]   w_sum;
    logic               w_ok;
    logic [CLASS_W-1:0] n_class;
    logic               w_f_ready;
    logic               r_valid;
    logic [CLASS_W-1:0] r_class;
    logic               r_ok;
    logic [COUNT_W-1:0] r_count;

    assign w_v[0]  = i_valid;
    assign o_ready = w_r[0];
    assign w_s[0]  = {{BCD_W{1'b0}}, i_card_number};

    for (genvar g = 0; g < NSTAGE; g++) begin : g_dig
        cnl_digit_stage #(
            .STEPS   (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_r[g]),
            .i_state (w_s[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_r[g+1]),
            .o_state (w_s[g+1])
        );
    end

    // Luhn weights: digit 0 is the rightmost; odd positions are doubled and
    // folded (2d - 9 above 9). The 4-bit wrap is harmless, results are 0..9.
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            w_dig[k] = w_s[NSTAGE].bcd[4*k +: 4];
            if (k[0]) begin
                w_wt[k] = (w_dig[k] >= 4'd5) ? w_dig[k] + w_dig[k] - 4'd9
                                             : w_dig[k] + w_dig[k];
            end else begin
                w_wt[k] = w_dig[k];
            end
        end
    end

    // Partial sums, four digits each; leading zeros weigh nothing.
    always_comb begin
        for (int g = 0; g < PART_N - 1; g++) begin
            n_e_part[g] = (PART_W'(w_wt[4*g])     + PART_W'(w_wt[4*g + 1]))
                        + (PART_W'(w_wt[4*g + 2]) + PART_W'(w_wt[4*g + 3]));
        end
        n_e_part[PART_N-1] = PART_W'(w_wt[DIGITS-1]);
    end

    // Highest nonzero digit gives the count and the two leading digits.
    always_comb begin
        n_e_count = '0;
        n_e_hi    = '0;
        n_e_lo    = '0;
        if (w_dig[0] != 4'd0) begin
            n_e_count = COUNT_W'(1);
            n_e_hi    = w_dig[0];
        end
        for (int k = 1; k < DIGITS; k++) begin
            if (w_dig[k] != 4'd0) begin
                n_e_count = COUNT_W'(k + 1);
                n_e_hi    = w_dig[k];
                n_e_lo    = w_dig[k-1];
            end
        end
    end

    assign w_e_ready   = !r_e_valid || w_f_ready;
    assign w_r[NSTAGE] = w_e_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_e_ready) begin
            r_e_valid <= w_v[NSTAGE];
        end
        if (w_e_ready && w_v[NSTAGE]) begin
            r_e_part  <= n_e_part;
            r_e_count <= n_e_count;
            r_e_hi    <= n_e_hi;
            r_e_lo    <= n_e_lo;
        end
    end

    // Final stage: total sum (<= 153), mod-10 test by matching the
    // multiples of ten, then the prefix check.
    assign w_sum = (SUM_W'(r_e_part[0]) + SUM_W'(r_e_part[1]))
                 + (SUM_W'(r_e_part[2]) + SUM_W'(r_e_part[3]))
                 + SUM_W'(r_e_part[4]);

    always_comb begin
        w_ok = 1'b0;
        for (int m = 0; m <= SUM_MAX; m += 10) begin
            if (w_sum == SUM_W'(m)) begin
                w_ok = 1'b1;
            end
        end
    end

    always_comb begin
        n_class = CLS_NONE;
        if (w_ok) begin
            if ((r_e_count == 5'd13 || r_e_count == 5'd16) && r_e_hi == 4'd4) begin
                n_class = CLS_P4;
            end
            if (r_e_count == 5'd15 && r_e_hi == 4'd3
                && (r_e_lo == 4'd4 || r_e_lo == 4'd7)) begin
                n_class = CLS_P3X;
            end
            if (r_e_count == 5'd16 && r_e_hi == 4'd5
                && r_e_lo >= 4'd1 && r_e_lo <= 4'd5) begin
                n_class = CLS_P5X;
            end
        end
    end

    assign w_f_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_f_ready) begin
            r_valid <= r_e_valid;
        end
        if (w_f_ready && r_e_valid) begin
            r_class <= n_class;
            r_ok    <= w_ok;
            r_count <= r_e_count;
        end
    end

    assign o_valid       = r_valid;
    assign o_card_class  = r_class;
    assign o_luhn_ok     = r_ok;
    assign o_digit_count = r_count;

    `CNL_ASSERT_IMP(a_class_needs_ok, i_clk, i_rst_n,
        o_valid && o_card_class != CLS_NONE, o_luhn_ok, "class without luhn pass")
    `CNL_ASSERT_IMP(a_count_range, i_clk, i_rst_n,
        o_valid, o_digit_count <= 5'd17, "digit count out of range")
    `CNL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_valid && !i_ready, o_valid && $stable(o_digit_count), "result dropped")
endmodule
